// ===== rtl/smrh_pkg.sv =====
`timescale 1ns / 1ps
// smrh_pkg: constants, controller states and control/status structs for the
// rolling-hash substring matcher; no dependencies

package smrh_pkg;

  localparam int MAX_PATTERN = 256;
  localparam int ADDR_W      = $clog2(MAX_PATTERN);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int CH_W        = 8;
  localparam int HASH_W      = 64;
  localparam int BASE_SH     = 7;                  // base 128
  localparam int SH_W        = $clog2(HASH_W) + 1; // drop shift, saturates at HASH_W

  localparam logic KIND_PATTERN = 1'b0;
  localparam logic KIND_TEXT    = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAT,
    ST_SUB,
    ST_ADD,
    ST_CHK,
    ST_CRD,
    ST_CCMP,
    ST_RES
  } state_t;

  typedef struct packed {
    logic load_in;
    logic pat_upd;
    logic txt_sub;
    logic txt_add;
    logic cmp_start;
    logic cmp_rd;
    logic cmp_step;
    logic res_done;
  } dp_cmd_t;

  typedef struct packed {
    logic is_text;
    logic is_last;
    logic skip;
    logic hash_hit;
    logic cmp_mismatch;
    logic cmp_last;
  } dp_stat_t;

endpackage

// ===== rtl/smrh_ram.sv =====
`timescale 1ns / 1ps
// smrh_ram: generic simple dual-port ram, one write and one registered read
// port; no dependencies

module smrh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/smrh_dp.sv =====
`timescale 1ns / 1ps
// smrh_dp: pattern and window stores, rolling hashes, counters and the
// window compare walk; depends on smrh_pkg and smrh_ram

module smrh_dp import smrh_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic [CH_W-1:0] in_ch,
  input  logic            in_kind,
  input  logic            in_last,
  input  dp_cmd_t         cmd,
  output dp_stat_t        stat,
  output logic            found,
  output logic            pattern_overflow
);

  // latched input beat
  logic [CH_W-1:0]   ch_q;
  logic              kind_q;
  logic              last_q;

  // pattern side
  logic [CNT_W-1:0]  pat_len;
  logic [HASH_W-1:0] pat_hash;
  logic [SH_W-1:0]   drop_sh;
  logic              ovf_seen;
  logic              pat_open;

  // text side
  logic [HASH_W-1:0] win_hash;
  logic [HASH_W-1:0] diff;
  logic [CNT_W-1:0]  text_cnt;
  logic [ADDR_W-1:0] win_pos;
  logic              match_seen;

  // compare walk
  logic [ADDR_W-1:0] cmp_k;
  logic [ADDR_W-1:0] cmp_idx;

  logic [CNT_W-1:0]  base_len;
  logic [HASH_W-1:0] base_hash;
  logic [SH_W-1:0]   base_sh;
  logic              base_ovf;
  logic              pat_full;
  logic [SH_W-1:0]   drop_sh_next;
  logic [HASH_W-1:0] pat_hash_next;

  logic [HASH_W-1:0] drop_term;
  logic              win_full;
  logic [CNT_W-1:0]  win_pos_inc;
  logic [ADDR_W-1:0] win_pos_next;
  logic [CNT_W-1:0]  cmp_idx_inc;
  logic [ADDR_W-1:0] cmp_idx_next;
  logic [CNT_W-1:0]  cmp_k_inc;
  logic [CNT_W-1:0]  text_cnt_next;

  logic              pram_we;
  logic [CH_W-1:0]   pram_rdata;
  logic [ADDR_W-1:0] wram_raddr;
  logic [CH_W-1:0]   wram_rdata;

  // a pattern byte arriving with no open pattern starts from scratch
  always_comb begin
    base_len  = pat_open ? pat_len  : '0;
    base_hash = pat_open ? pat_hash : '0;
    base_sh   = pat_open ? drop_sh  : '0;
    base_ovf  = pat_open ? ovf_seen : 1'b0;
    pat_full  = (base_len == CNT_W'(MAX_PATTERN));
    pat_hash_next = (base_hash << BASE_SH) + HASH_W'(ch_q);
    if (base_len == '0) begin
      drop_sh_next = '0;
    end else if (base_sh >= SH_W'(HASH_W - BASE_SH)) begin
      drop_sh_next = SH_W'(HASH_W);
    end else begin
      drop_sh_next = base_sh + SH_W'(BASE_SH);
    end
  end

  // drop weight is 128^(len-1), a pure shift that vanishes once past 64 bits
  always_comb begin
    if (drop_sh[SH_W-1]) begin
      drop_term = '0;
    end else begin
      drop_term = {{(HASH_W-CH_W){1'b0}}, wram_rdata} << drop_sh[SH_W-2:0];
    end
    win_full     = (text_cnt >= pat_len);
    win_pos_inc  = {1'b0, win_pos} + CNT_W'(1);
    win_pos_next = (win_pos_inc >= pat_len) ? '0 : win_pos_inc[ADDR_W-1:0];
    cmp_idx_inc  = {1'b0, cmp_idx} + CNT_W'(1);
    cmp_idx_next = (cmp_idx_inc >= pat_len) ? '0 : cmp_idx_inc[ADDR_W-1:0];
    cmp_k_inc    = {1'b0, cmp_k} + CNT_W'(1);
    text_cnt_next = (text_cnt == CNT_W'(MAX_PATTERN)) ? text_cnt : text_cnt + CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      ch_q   <= in_ch;
      kind_q <= in_kind;
      last_q <= in_last;
    end
    if (cmd.txt_sub) begin
      diff <= win_hash - (win_full ? drop_term : '0);
    end
    if (cmd.cmp_start) begin
      cmp_k   <= '0;
      cmp_idx <= win_pos;
    end else if (cmd.cmp_step) begin
      cmp_k   <= cmp_k_inc[ADDR_W-1:0];
      cmp_idx <= cmp_idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pat_len    <= '0;
      pat_hash   <= '0;
      drop_sh    <= '0;
      ovf_seen   <= 1'b0;
      pat_open   <= 1'b0;
      win_hash   <= '0;
      text_cnt   <= '0;
      win_pos    <= '0;
      match_seen <= 1'b0;
    end else begin
      if (cmd.load_in && in_kind == KIND_TEXT) begin
        pat_open <= 1'b0;
      end
      if (cmd.pat_upd) begin
        pat_open <= !last_q;
        if (pat_full) begin
          pat_len  <= base_len;
          pat_hash <= base_hash;
          drop_sh  <= base_sh;
          ovf_seen <= 1'b1;
        end else begin
          pat_len  <= base_len + CNT_W'(1);
          pat_hash <= pat_hash_next;
          drop_sh  <= drop_sh_next;
          ovf_seen <= base_ovf;
        end
        if (!pat_open) begin
          win_hash   <= '0;
          text_cnt   <= '0;
          win_pos    <= '0;
          match_seen <= 1'b0;
        end
      end
      if (cmd.txt_add) begin
        win_hash <= (diff << BASE_SH) + HASH_W'(ch_q);
        win_pos  <= win_pos_next;
        text_cnt <= text_cnt_next;
      end
      if (cmd.cmp_step && !stat.cmp_mismatch && stat.cmp_last) begin
        match_seen <= 1'b1;
      end
      if (cmd.res_done) begin
        win_hash   <= '0;
        text_cnt   <= '0;
        win_pos    <= '0;
        match_seen <= 1'b0;
      end
    end
  end

  assign pram_we    = cmd.pat_upd && !pat_full;
  assign wram_raddr = cmd.cmp_rd ? cmp_idx : win_pos;

  smrh_ram #(.WIDTH(CH_W), .DEPTH(MAX_PATTERN)) u_pat_ram (
    .clk   (clk),
    .we    (pram_we),
    .waddr (base_len[ADDR_W-1:0]),
    .wdata (ch_q),
    .raddr (cmp_k),
    .rdata (pram_rdata)
  );

  smrh_ram #(.WIDTH(CH_W), .DEPTH(MAX_PATTERN)) u_win_ram (
    .clk   (clk),
    .we    (cmd.txt_add),
    .waddr (win_pos),
    .wdata (ch_q),
    .raddr (wram_raddr),
    .rdata (wram_rdata)
  );

  always_comb begin
    stat.is_text      = (kind_q == KIND_TEXT);
    stat.is_last      = last_q;
    stat.skip         = ovf_seen || (pat_len == '0);
    stat.hash_hit     = win_full && (win_hash == pat_hash);
    stat.cmp_mismatch = (pram_rdata != wram_rdata);
    stat.cmp_last     = (cmp_k_inc == pat_len);
  end

  assign found            = !ovf_seen && ((pat_len == '0) || match_seen);
  assign pattern_overflow = ovf_seen;

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    pat_len <= CNT_W'(MAX_PATTERN))
    else $error("pattern length beyond store");

  a_ring_pos: assert property (@(posedge clk) disable iff (rst)
    (pat_len == '0) || ({1'b0, win_pos} < pat_len))
    else $error("window ring position outside pattern length");

  a_match_needs_window: assert property (@(posedge clk) disable iff (rst)
    $rose(match_seen) |-> (text_cnt >= pat_len) && (pat_len != '0))
    else $error("match flagged before window filled");

endmodule

// ===== rtl/smrh_ctrl.sv =====
`timescale 1ns / 1ps
// smrh_ctrl: sequencer for pattern update, hash roll, hit check and window
// compare walk; depends on smrh_pkg

module smrh_ctrl import smrh_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_PAT;
        end
      end
      ST_PAT: begin
        // kind is known only after the beat is latched
        if (stat.is_text) begin
          state_next = ST_SUB;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_SUB: begin
        if (stat.skip) begin
          state_next = stat.is_last ? ST_RES : ST_IDLE;
        end else begin
          state_next = ST_ADD;
        end
      end
      ST_ADD: state_next = ST_CHK;
      ST_CHK: begin
        if (stat.hash_hit) begin
          state_next = ST_CRD;
        end else begin
          state_next = stat.is_last ? ST_RES : ST_IDLE;
        end
      end
      ST_CRD: state_next = ST_CCMP;
      ST_CCMP: begin
        if (stat.cmp_mismatch || stat.cmp_last) begin
          state_next = stat.is_last ? ST_RES : ST_IDLE;
        end else begin
          state_next = ST_CRD;
        end
      end
      ST_RES: begin
        if (out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      ST_PAT:  cmd.pat_upd   = !stat.is_text;
      ST_SUB:  cmd.txt_sub   = !stat.skip;
      ST_ADD:  cmd.txt_add   = 1'b1;
      ST_CHK:  cmd.cmp_start = stat.hash_hit;
      ST_CRD:  cmd.cmp_rd    = 1'b1;
      ST_CCMP: cmd.cmp_step  = 1'b1;
      ST_RES: begin
        out_valid    = 1'b1;
        cmd.res_done = out_ready;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ===== rtl/substring_match_rolling_hash_unit.sv =====
`timescale 1ns / 1ps
// Rabin-Karp substring matcher: a pattern is streamed in byte by byte, then
// a text, and one beat per text answers whether the pattern occurred in it.
// A pattern beat is accepted and latched, then stored with a hash update.
// A text beat passes accept and latch, kind decode, hash subtract, hash
// roll and hit check, or ends at the subtract state when there is no usable
// pattern, since one shared sequencer walks each beat through the 64-bit
// hash datapath. A hash hit adds a read and a compare state per pattern byte
// for the confirm walk, bound by the single read port of each byte store.
// The last text beat adds a result beat, which is held until taken; no beat
// is accepted meanwhile. Patterns longer than 256 bytes flag pattern_overflow.
// depends on smrh_pkg, smrh_ctrl, smrh_dp

module substring_match_rolling_hash_unit import smrh_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [CH_W-1:0] s_axis_tdata,   // [7:0] ch
  input  logic            s_axis_tuser,   // [0] kind: 0 pattern, 1 text
  input  logic            s_axis_tlast,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [7:0]      m_axis_tdata    // [0] found, [1] pattern_overflow, rest zero
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     found;
  logic     pattern_overflow;

  smrh_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  smrh_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .in_ch            (s_axis_tdata),
    .in_kind          (s_axis_tuser),
    .in_last          (s_axis_tlast),
    .cmd              (cmd),
    .stat             (stat),
    .found            (found),
    .pattern_overflow (pattern_overflow)
  );

  assign m_axis_tdata = {6'b0, pattern_overflow, found};

  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while a beat is in flight");

  a_no_input_with_result: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input ready while result pending");

  a_overflow_not_found: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
    else $error("found reported together with overflow");

endmodule
